[rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_REAR,
        CMD_POP_FRONT,
        CMD_POP_REAR,
        CMD_ROTATE
    } dq_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } dq_state_t;

    typedef struct packed {
        logic               valid;
        logic signed [WORD_W-1:0] word;
    } dq_slot_t;

    typedef struct packed {
        dq_cmd_t            cmd;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] wrap_word;
    } dq_ctl_t;

endpackage

[rtl/dq_cell.sv]
// One slot of the queue chain; shifts toward either neighbor on command.
module dq_cell
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dq_ctl_t                  ctl,
    input  dq_slot_t                 prev,
    input  dq_slot_t                 nxt,
    output dq_slot_t                 slot,
    output logic signed [WORD_W-1:0] tail_word
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     is_tail;

    assign is_tail = valid_reg && !nxt.valid;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        unique case (ctl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_PUSH_FRONT:
            begin
                valid_next = prev.valid;
                word_next  = prev.word;
            end
            CMD_PUSH_REAR:
            begin
                if (!valid_reg && prev.valid)
                begin
                    valid_next = 1'b1;
                    word_next  = ctl.value;
                end
            end
            CMD_POP_FRONT:
            begin
                valid_next = nxt.valid;
                word_next  = nxt.word;
            end
            CMD_POP_REAR:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_ROTATE:
            begin
                if (valid_reg)
                begin
                    word_next = nxt.valid ? nxt.word : ctl.wrap_word;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign slot.valid = valid_reg;
    assign slot.word  = word_reg;
    assign tail_word  = is_tail ? word_reg : '0;

endmodule

[rtl/double_ended_queue.sv]
// Double-ended queue of signed words held in a shifting chain of cells.
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+---------------------
//  in      | input     | in_valid / in_stall  | operation, value
//  out     | output    | out_valid / out_stall| word, status, last
//
// Insert and delete: accepted when output is free; result registered next cycle.
// Listing: one result beat per stored word, rotating the cell chain once per
// cycle if output is free; input stalls until done. An empty listing is one beat.
// Reset clears every cell's valid flag at once; no clearing pass.
// A stalled output beat holds the chain; input waits until the beat drains.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [WORD_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [WORD_W-1:0]   word,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    dq_state_t                state_reg;
    dq_state_t                state_next;
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     last_reg;

    dq_slot_t                 slots [DEPTH];
    logic signed [WORD_W-1:0] tails [DEPTH];
    logic signed [WORD_W-1:0] tail_word;
    dq_ctl_t                  ctl;

    logic                     out_free;
    logic                     in_fire;
    logic                     empty;
    logic                     full;
    logic                     emit;
    logic signed [WORD_W-1:0] emit_word;
    logic [STATUS_W-1:0]      emit_status;
    logic                     emit_last;
    dq_cmd_t                  cmd;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg == ST_LIST) || !out_free;
    assign in_fire  = in_valid && !in_stall;
    assign empty    = !slots[0].valid;
    assign full     = slots[DEPTH-1].valid;

    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | tails[i];
        end
    end

    assign ctl.cmd       = cmd;
    assign ctl.value     = value;
    assign ctl.wrap_word = slots[0].word;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dq_slot_t prev;
        dq_slot_t nxt;

        if (i == 0)
        begin : g_first
            assign prev.valid = 1'b1;
            assign prev.word  = value;
        end
        else
        begin : g_mid
            assign prev = slots[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign nxt.valid = 1'b0;
            assign nxt.word  = '0;
        end
        else
        begin : g_body
            assign nxt = slots[i+1];
        end

        dq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev      (prev),
            .nxt       (nxt),
            .slot      (slots[i]),
            .tail_word (tails[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && operation == OP_LIST && !empty)
                begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                if (out_free && remain_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = CMD_HOLD;
        emit        = 1'b0;
        emit_word   = '0;
        emit_status = STATUS_OK;
        emit_last   = 1'b1;
        occ_next    = occ_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (operation) inside
                        OP_INS_FRONT, OP_INS_REAR:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd      = (operation == OP_INS_FRONT) ? CMD_PUSH_FRONT
                                                                       : CMD_PUSH_REAR;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_REAR:
                        begin
                            emit = 1'b1;
                            if (empty)
                            begin
                                emit_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd       = (operation == OP_DEL_FRONT) ? CMD_POP_FRONT
                                                                        : CMD_POP_REAR;
                                emit_word = (operation == OP_DEL_FRONT) ? slots[0].word
                                                                        : tail_word;
                                occ_next  = occ_reg - CNT_W'(1);
                            end
                        end
                        OP_LIST:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                remain_next = occ_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    cmd         = CMD_ROTATE;
                    emit        = 1'b1;
                    emit_word   = slots[0].word;
                    emit_last   = (remain_reg == CNT_W'(1));
                    remain_next = remain_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            remain_reg <= remain_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg   <= emit_word;
            status_reg <= emit_status;
            last_reg   <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

[rtl/dq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WORD_W-1:0] word,
    input  logic [STATUS_W-1:0]      status,
    input  logic                     last
);

    // held beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word) && $stable(status)
                                   && $stable(last))
        else $error("stalled output beat changed");

    // insert or delete answers on the next cycle
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (operation == OP_INS_FRONT || operation == OP_INS_REAR
            || operation == OP_DEL_FRONT || operation == OP_DEL_REAR)
        |=> out_valid && last)
        else $error("missing reply to insert or delete");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STATUS_FULL)
        else $error("undefined status code");

    // empty and full reports are single zero beats
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last && word == '0)
        else $error("empty or full report malformed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word      (word),
    .status    (status),
    .last      (last)
);
